// File: sv/slm_pkg.sv
// Shared types and constants for the sorted list merge unit.
// Used by the front end, the merge engine and the top level; depends on nothing.
`default_nettype none

package slm_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int SUM_W    = 7;
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0] CAP_CNT = 6'd32;

    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;
    localparam logic [Q_CNT_W-1:0] Q_FULL = 3'd4;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } queue_head_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

endpackage

`default_nettype wire

// File: sv/sorted_list_merge_unit.sv
// Top level of the sorted list merge unit.
// Instantiates slm_front and slm_merge; depends on slm_pkg.
//
// The input channel carries one command word at a time: load into list A,
// load into list B, or run the merge. Command code 3 is accepted and dropped.
// Each list holds up to 32 values; further loads into a full list are dropped.
// A run emits the merged ascending sequence on the result channel, one word
// per value, with m_last set on the final word; B's value goes first on a tie.
// A run on two empty lists emits nothing. Both lists are empty after a run.
// Words pass through a four-entry queue to the merge engine, so loads are
// taken at one per cycle while the queue has room. A run holds the engine
// from its pop until its last result has been put in the output register.
// Words queued behind a run wait until its last result has been registered.
// The output register only advances when it is empty or m_ready takes its word;
// while the receiver stalls the merge pauses and the queue fills, then s_ready falls.
// A synchronous reset empties the queue, both lists and the output register.
`default_nettype none

module sorted_list_merge_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_command,
    input  wire logic signed [slm_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [slm_pkg::DATA_W-1:0]      m_merged_value,
    output logic                                   m_last
);

    slm_pkg::queue_head_t head;
    logic                 pop;

    slm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .head      (head),
        .pop       (pop)
    );

    slm_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_merged_value (m_merged_value),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

// File: sv/slm_front.sv
// Front end of the sorted list merge unit: accepts input words, classifies them
// and holds them in a short queue for the merge engine. Depends on slm_pkg.
`default_nettype none

module slm_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_command,
    input  wire logic signed [slm_pkg::DATA_W-1:0] s_value,
    output slm_pkg::queue_head_t                   head,
    input  wire logic                              pop
);

    slm_pkg::cmd_entry_t              queue_mem [4];
    logic [slm_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [slm_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [slm_pkg::Q_CNT_W-1:0]      count_reg, count_next;
    logic                             push;
    logic                             known;
    slm_pkg::op_t                     op;

    always_comb begin
        known = 1'b1;
        op    = slm_pkg::OP_RUN;
        case (s_command)
            slm_pkg::CMD_LOAD_A: op = slm_pkg::OP_LOAD_A;
            slm_pkg::CMD_LOAD_B: op = slm_pkg::OP_LOAD_B;
            slm_pkg::CMD_RUN:    op = slm_pkg::OP_RUN;
            default:             known = 1'b0;
        endcase
    end

    assign s_ready = (count_reg != slm_pkg::Q_FULL);
    assign push    = s_valid && s_ready && known;

    assign head.valid = (count_reg != '0);
    assign head.entry = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= '{op: op, value: s_value};
        end
    end

endmodule

`default_nettype wire

// File: sv/slm_merge.sv
// Merge engine of the sorted list merge unit: stores the two lists and emits
// the merged sequence through an output register. Depends on slm_pkg.
`default_nettype none

module slm_merge (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire slm_pkg::queue_head_t              head,
    output logic                                   pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [slm_pkg::DATA_W-1:0]      m_merged_value,
    output logic                                   m_last
);

    localparam slm_pkg::state_t ST_IDLE_C  = slm_pkg::ST_IDLE;
    localparam slm_pkg::state_t ST_MERGE_C = slm_pkg::ST_MERGE;

    logic signed [slm_pkg::DATA_W-1:0] a_mem [slm_pkg::CAPACITY];
    logic signed [slm_pkg::DATA_W-1:0] b_mem [slm_pkg::CAPACITY];

    slm_pkg::state_t              state_reg, state_next;
    logic [slm_pkg::CNT_W-1:0]    cnt_a_reg, cnt_a_next;
    logic [slm_pkg::CNT_W-1:0]    cnt_b_reg, cnt_b_next;
    logic [slm_pkg::CNT_W-1:0]    idx_a_reg, idx_a_next;
    logic [slm_pkg::CNT_W-1:0]    idx_b_reg, idx_b_next;
    logic                         valid_reg, valid_next;
    logic signed [slm_pkg::DATA_W-1:0] value_reg, value_next;
    logic                         last_reg, last_next;

    logic                              wr_a, wr_b;
    logic                              out_free;
    logic                              take_a;
    logic                              is_last;
    logic signed [slm_pkg::DATA_W-1:0] head_a, head_b;
    logic [slm_pkg::SUM_W-1:0]         total, taken;

    assign pop      = head.valid && (state_reg == ST_IDLE_C);
    assign out_free = !valid_reg || m_ready;
    assign head_a   = a_mem[idx_a_reg[slm_pkg::IDX_W-1:0]];
    assign head_b   = b_mem[idx_b_reg[slm_pkg::IDX_W-1:0]];
    assign take_a   = (idx_a_reg < cnt_a_reg)
                      && ((idx_b_reg >= cnt_b_reg) || (head_a < head_b));
    assign total    = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign taken    = {1'b0, idx_a_reg} + {1'b0, idx_b_reg} + 7'd1;
    assign is_last  = (taken == total);

    always_comb begin
        state_next = state_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        idx_a_next = idx_a_reg;
        idx_b_next = idx_b_reg;
        valid_next = valid_reg;
        value_next = value_reg;
        last_next  = last_reg;
        wr_a       = 1'b0;
        wr_b       = 1'b0;

        if (m_ready) begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE_C: begin
                if (pop) begin
                    case (head.entry.op)
                        slm_pkg::OP_LOAD_A: begin
                            if (cnt_a_reg < slm_pkg::CAP_CNT) begin
                                wr_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                        end
                        slm_pkg::OP_LOAD_B: begin
                            if (cnt_b_reg < slm_pkg::CAP_CNT) begin
                                wr_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                        end
                        slm_pkg::OP_RUN: begin
                            idx_a_next = '0;
                            idx_b_next = '0;
                            if (total != '0) begin
                                state_next = ST_MERGE_C;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE_C: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    last_next  = is_last;
                    if (take_a) begin
                        value_next = head_a;
                        idx_a_next = idx_a_reg + 1'b1;
                    end else begin
                        value_next = head_b;
                        idx_b_next = idx_b_reg + 1'b1;
                    end
                    if (is_last) begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        state_next = ST_IDLE_C;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE_C;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE_C;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        last_reg  <= last_next;
        if (wr_a) begin
            a_mem[cnt_a_reg[slm_pkg::IDX_W-1:0]] <= head.entry.value;
        end
        if (wr_b) begin
            b_mem[cnt_b_reg[slm_pkg::IDX_W-1:0]] <= head.entry.value;
        end
    end

    assign m_valid        = valid_reg;
    assign m_merged_value = value_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

// File: sv/slm_checker.sv
// Port-level checks for the sorted list merge unit, bound to its top level.
// Depends on slm_pkg for the data width.
`default_nettype none

module slm_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic [1:0]                        s_command,
    input wire logic signed [slm_pkg::DATA_W-1:0] s_value,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic signed [slm_pkg::DATA_W-1:0] m_merged_value,
    input wire logic                              m_last
);

    // No result word is offered straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word offered after reset");

    // The queue is empty after reset, so the input side is ready.
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // A stalled result word holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_merged_value) && $stable(m_last)))
        else $error("stalled result word changed");

    // Within a sequence the next word follows in the cycle after a word is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("gap inside merged sequence");

    // A waiting input word keeps its command and value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_command) && $stable(s_value)))
        else $error("waiting input word changed");

endmodule

bind sorted_list_merge_unit slm_checker u_slm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_command      (s_command),
    .s_value        (s_value),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_merged_value (m_merged_value),
    .m_last         (m_last)
);

`default_nettype wire
